// ----- rtl/core/mhpq_pkg.sv -----
`default_nettype none
package mhpq_pkg;
  localparam int DEPTH = 1024;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 31 + 16 + 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_DECREASE = 2'd2;
  localparam logic [1:0] KIND_PEEK = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_KEY_HIGHER = 3'd3;
  localparam logic [2:0] ST_BAD_POS = 3'd4;

  typedef struct packed {
    logic [30:0] time_key;
    logic [15:0] prio;
    logic [31:0] payload;
  } entry_t;

  function automatic logic precedes(entry_t a, entry_t b);
    if (a.time_key != b.time_key) return a.time_key < b.time_key;
    return a.prio < b.prio;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/mhpq_ram.sv -----
`default_nettype none
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/min_heap_priority_queue_unit.sv -----
`default_nettype none
// Binary min-heap priority queue of up to DEPTH entries held in one RAM with a
// registered read (slot i of the heap at address i-1). One item is worked on at
// a time and each item gives one result item. Rejected items (full, empty, bad
// position) go straight to the result; peek reads the root, and a decrease key
// with a higher time stops once the old entry has been read. Insert sifts the
// new entry up from the new last slot, and decrease key from the given slot
// after a check read. Extract reads the root, moves the last entry to the root
// and sifts it down. The steps come from the single read port and its registered
// read: each level of a sift up needs one parent read, each level of a sift down
// needs two child reads. The entry being sifted is held in a register, so each
// level costs one write. A finished result waits in the output register while
// the next item is taken.
module min_heap_priority_queue_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // kind[1:0], new_time[32:2], new_priority[48:33], new_frequency[64:49],
  // new_tag[80:65], position[91:81], zero fill
  input  wire logic [95:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[2:0], out_time[33:3], out_priority[49:34], out_frequency[65:50],
  // out_tag[81:66], occupancy[92:82], zero fill
  output logic      [95:0]  m_tdata
);
  import mhpq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK = 4'd1;
  localparam logic [3:0] S_ROOT = 4'd2;
  localparam logic [3:0] S_LAST = 4'd3;
  localparam logic [3:0] S_UPRD = 4'd4;
  localparam logic [3:0] S_UP = 4'd5;
  localparam logic [3:0] S_DNL = 4'd6;
  localparam logic [3:0] S_DNR = 4'd7;
  localparam logic [3:0] S_DN = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state;
  logic [1:0] kind;
  logic [CW-1:0] count, pos;
  logic have_r;
  entry_t cur, left_e, in_e, res, child;
  logic [2:0] status;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  logic [CW:0] lpos, rpos;
  logic [CW-1:0] parent;
  logic take_r, up_move, down_move, emit;

  mhpq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_e = {s_tdata[32:2], s_tdata[48:33], s_tdata[64:49], s_tdata[80:65]};
  assign s_tready = (state == S_IDLE);

  assign lpos = {pos, 1'b0};
  assign rpos = {pos, 1'b1};
  assign parent = pos >> 1;

  // smaller child, then whether it beats the entry being sifted down
  assign take_r = have_r && precedes(rdata, left_e);
  assign child = take_r ? rdata : left_e;
  assign down_move = precedes(child, cur);
  assign up_move = precedes(cur, rdata);
  assign emit = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    we = 1'b0;
    waddr = AW'(pos - CW'(1));
    wdata = cur;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (s_tdata[1:0] == KIND_DECREASE) raddr = AW'(s_tdata[91:81] - 11'd1);
      end
      S_ROOT: raddr = AW'(count - CW'(1));
      S_UPRD: begin
        raddr = AW'(parent - CW'(1));
        if (pos == CW'(1)) we = 1'b1;
      end
      S_UP: begin
        we = 1'b1;
        if (up_move) wdata = rdata;
      end
      S_DNL: begin
        raddr = AW'(lpos - (CW+1)'(1));
        if (lpos > {1'b0, count}) we = 1'b1;
      end
      S_DNR: raddr = AW'(rpos - (CW+1)'(1));
      S_DN: begin
        we = 1'b1;
        if (down_move) wdata = child;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= emit || (m_tvalid && !m_tready);
      if (emit)
        m_tdata <= {3'b0, count, res.payload[15:0], res.payload[31:16], res.prio,
                    res.time_key, status};
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          kind <= s_tdata[1:0];
          cur <= in_e;
          res <= '0;
          status <= ST_OK;
          case (s_tdata[1:0])
            KIND_INSERT: begin
              if (count >= CW'(DEPTH)) begin
                status <= ST_FULL;
                state <= S_DONE;
              end else begin
                count <= count + CW'(1);
                pos <= count + CW'(1);
                state <= S_UPRD;
              end
            end
            KIND_DECREASE: begin
              pos <= s_tdata[91:81];
              if (s_tdata[91:81] == 11'd0 || s_tdata[91:81] > count) begin
                status <= ST_BAD_POS;
                state <= S_DONE;
              end else state <= S_CHK;
            end
            default: begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state <= S_DONE;
              end else state <= S_ROOT;
            end
          endcase
        end
        S_CHK: begin
          if (cur.time_key > rdata.time_key) begin
            status <= ST_KEY_HIGHER;
            state <= S_DONE;
          end else state <= S_UPRD;
        end
        S_ROOT: begin
          res <= rdata;
          if (kind == KIND_PEEK) state <= S_DONE;
          else state <= S_LAST;
        end
        S_LAST: begin
          // last entry goes to the root and sifts down
          cur <= rdata;
          count <= count - CW'(1);
          pos <= CW'(1);
          state <= S_DNL;
        end
        S_UPRD: begin
          if (pos == CW'(1)) state <= S_DONE;
          else state <= S_UP;
        end
        S_UP: begin
          if (up_move) begin
            pos <= parent;
            state <= S_UPRD;
          end else state <= S_DONE;
        end
        S_DNL: begin
          if (lpos > {1'b0, count}) state <= S_DONE;
          else state <= S_DNR;
        end
        S_DNR: begin
          left_e <= rdata;
          have_r <= (rpos <= {1'b0, count});
          state <= S_DN;
        end
        S_DN: begin
          if (down_move) begin
            pos <= take_r ? rpos[CW-1:0] : lpos[CW-1:0];
            state <= S_DNL;
          end else state <= S_DONE;
        end
        S_DONE: begin
          if (emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  ap_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("count overflow");
  ap_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE) else $error("result out of order");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  ap_up_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_UP |-> pos > CW'(1)) else $error("sift up past root");
endmodule
`default_nettype wire
